@@ rtl/core/etbd_pkg.sv @@
// Package for the escaped text to binary decoder.
// Holds the decode mode codes, character codes and the state/result structs.
// No dependencies.
package etbd_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_TILDE = 3'd1,
        MODE_CARET = 3'd2,
        MODE_BSL   = 3'd3,
        MODE_NUM   = 3'd4
    } t_mode;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6e;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_TILDE = 8'h7e;

    localparam logic [7:0] BYTE_DEL = 8'h7f;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_FF  = 8'h0c;
    localparam logic [7:0] BYTE_CR  = 8'h0d;
    localparam logic [7:0] BYTE_ESC = 8'h1b;

    localparam logic [1:0] HEX_DIGITS = 2'd2;
    localparam logic [1:0] OCT_DIGITS = 2'd3;

    typedef struct packed {
        t_mode       mode;
        logic        high;
        logic [8:0]  value;
        logic [1:0]  count;
        logic        is_hex;
    } t_dec_state;

    typedef struct packed {
        logic        vld0;
        logic [7:0]  byte0;
        logic        last0;
        logic        vld1;
        logic [7:0]  byte1;
    } t_dec_res;

endpackage

@@ rtl/core/etbd_step.sv @@
// Next-state and result logic for one character of escaped text.
// Depends on etbd_pkg.
// Pure combinational: current state and character in, next state and up to two bytes out.
module etbd_step (
    input  etbd_pkg::t_dec_state i_state,
    input  logic [7:0]           i_char,
    input  logic                 i_end,
    output etbd_pkg::t_dec_state o_state,
    output etbd_pkg::t_dec_res   o_res
);
    import etbd_pkg::*;

    t_dec_state st;
    logic       v0;
    logic [7:0] b0;
    logic       v1;
    logic [7:0] b1;
    logic [7:0] flag8;
    logic [7:0] c7;
    logic       is_ws;
    logic       dig_ok;
    logic [3:0] dig;
    logic       pl_emit;
    t_mode      pl_mode;
    logic [8:0] nv;
    logic [1:0] ncnt;
    logic       num_done;

    always_comb begin
        flag8 = {i_state.high, 7'd0};
        c7    = {1'b0, i_char[6:0]};
        is_ws = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));

        dig_ok = 1'b0;
        dig    = 4'd0;
        if (i_char[7:3] == 5'b00110) begin
            dig_ok = 1'b1;
            dig    = {1'b0, i_char[2:0]};
        end else if (i_state.is_hex) begin
            if (i_char == 8'h38 || i_char == 8'h39) begin
                dig_ok = 1'b1;
                dig    = i_char[3:0];
            end else if ((i_char >= 8'h61 && i_char <= 8'h66) ||
                         (i_char >= 8'h41 && i_char <= 8'h46)) begin
                dig_ok = 1'b1;
                dig    = i_char[3:0] + 4'd9;
            end
        end

        pl_emit = 1'b0;
        pl_mode = MODE_PLAIN;
        unique case (i_char)
            CH_TILDE: pl_mode = MODE_TILDE;
            CH_CARET: pl_mode = MODE_CARET;
            CH_BSL:   pl_mode = MODE_BSL;
            default:  pl_emit = 1'b1;
        endcase

        if (i_state.count == 2'd0) begin
            nv = {5'd0, dig};
        end else if (i_state.is_hex) begin
            nv = {i_state.value[4:0], dig};
        end else begin
            nv = {i_state.value[5:0], dig[2:0]};
        end
        ncnt     = i_state.count + 2'd1;
        num_done = i_state.is_hex ? (ncnt == HEX_DIGITS) : (ncnt == OCT_DIGITS);

        st = i_state;
        v0 = 1'b0;
        b0 = 8'd0;
        v1 = 1'b0;
        b1 = 8'd0;

        unique case (i_state.mode)
            MODE_TILDE: begin
                if (c7 == CH_CARET) begin
                    st.mode = MODE_CARET;
                end else if (c7 == CH_BSL) begin
                    st.mode = MODE_BSL;
                end else begin
                    v0      = 1'b1;
                    b0      = flag8 | c7;
                    st.high = 1'b0;
                    st.mode = MODE_PLAIN;
                end
            end
            MODE_CARET: begin
                v0      = 1'b1;
                b0      = flag8 | ((i_char == CH_QMARK) ? BYTE_DEL : {3'd0, i_char[4:0]});
                st.high = 1'b0;
                st.mode = MODE_PLAIN;
            end
            MODE_BSL: begin
                st.mode = MODE_PLAIN;
                unique case (i_char)
                    CH_LF: begin
                    end
                    CH_LO_X, CH_UP_X: begin
                        st.mode   = MODE_NUM;
                        st.is_hex = 1'b1;
                        st.value  = {1'b0, i_char};
                        st.count  = 2'd0;
                    end
                    CH_ZERO: begin
                        st.mode   = MODE_NUM;
                        st.is_hex = 1'b0;
                        st.value  = {1'b0, i_char};
                        st.count  = 2'd0;
                    end
                    default: begin
                        v0      = 1'b1;
                        st.high = 1'b0;
                        unique case (i_char)
                            CH_LO_D:          b0 = flag8 | BYTE_DEL;
                            CH_LO_N:          b0 = flag8 | BYTE_LF;
                            CH_LO_R:          b0 = flag8 | BYTE_CR;
                            CH_LO_F:          b0 = flag8 | BYTE_FF;
                            CH_LO_T:          b0 = flag8 | BYTE_TAB;
                            CH_LO_B:          b0 = flag8 | BYTE_BS;
                            CH_LO_E, CH_UP_E: b0 = flag8 | BYTE_ESC;
                            default:          b0 = flag8 | i_char;
                        endcase
                    end
                endcase
            end
            MODE_NUM: begin
                if (!dig_ok) begin
                    if (!(i_state.count == 2'd0 && is_ws)) begin
                        v0        = 1'b1;
                        b0        = flag8 | i_state.value[7:0];
                        st.value  = 9'd0;
                        st.count  = 2'd0;
                        st.is_hex = 1'b0;
                        st.high   = 1'b0;
                        st.mode   = pl_mode;
                        if (pl_emit) begin
                            v1 = 1'b1;
                            b1 = i_char;
                        end else if (pl_mode == MODE_TILDE) begin
                            st.high = 1'b1;
                        end
                    end
                end else if (num_done) begin
                    v0        = 1'b1;
                    b0        = flag8 | nv[7:0];
                    st.value  = 9'd0;
                    st.count  = 2'd0;
                    st.is_hex = 1'b0;
                    st.high   = 1'b0;
                    st.mode   = MODE_PLAIN;
                end else begin
                    st.value = nv;
                    st.count = ncnt;
                end
            end
            default: begin
                st.mode = pl_mode;
                if (pl_emit) begin
                    v0      = 1'b1;
                    b0      = flag8 | i_char;
                    st.high = 1'b0;
                end else if (pl_mode == MODE_TILDE) begin
                    st.high = 1'b1;
                end
            end
        endcase

        if (i_end) begin
            if (st.mode == MODE_NUM) begin
                if (v0) begin
                    v1 = 1'b1;
                    b1 = {st.high, 7'd0} | st.value[7:0];
                end else begin
                    v0 = 1'b1;
                    b0 = {st.high, 7'd0} | st.value[7:0];
                end
            end
            st.mode   = MODE_PLAIN;
            st.high   = 1'b0;
            st.value  = 9'd0;
            st.count  = 2'd0;
            st.is_hex = 1'b0;
        end

        o_state     = st;
        o_res.vld0  = v0;
        o_res.byte0 = b0;
        o_res.last0 = v0 && !v1;
        o_res.vld1  = v1;
        o_res.byte1 = b1;
    end

endmodule

@@ rtl/core/escaped_text_to_binary_decoder_unit.sv @@
// Top level of the escaped text to binary decoder.
// Depends on etbd_pkg and etbd_step.
//
// Slave stream: one character per transaction, tdata = text_char, tlast = end of text.
// Master stream: one restored byte per transaction, tdata = out_byte,
// tlast = last byte caused by the input character.
// Each character yields zero, one or two bytes. The decoder state is updated
// in the cycle a character is accepted and its bytes are written to a
// four-entry output queue; they are offered behind any bytes already queued.
// Throughput: one character per cycle while o_s_axis_tready is high; a character
// that gives two bytes takes two transactions on the single output port.
// o_s_axis_tready is high while the queue has at least two free entries,
// so a stalled receiver fills the queue and then holds off the sender.
// Reset (synchronous, active low) empties the queue and returns the decoder
// to plain-character mode with the high-bit flag clear.
module escaped_text_to_binary_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_char
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);
    import etbd_pkg::*;

    t_dec_state r_state;
    t_dec_state n_state;
    t_dec_res   w_res;

    logic [8:0] r_fifo [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       w_acc;
    logic       w_pop;
    logic [1:0] w_npush;

    etbd_step u_step (
        .i_state (r_state),
        .i_char  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .o_state (n_state),
        .o_res   (w_res)
    );

    assign o_s_axis_tready = (r_count <= 3'd2);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != 3'd0);
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = r_fifo[r_rd_ptr][8:1];
    assign o_m_axis_tlast  = r_fifo[r_rd_ptr][0];
    assign w_npush         = w_acc ? ({1'b0, w_res.vld0} + {1'b0, w_res.vld1}) : 2'd0;
    assign n_count         = r_count + {1'b0, w_npush} - {2'd0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '{mode: MODE_PLAIN, high: 1'b0, value: 9'd0, count: 2'd0, is_hex: 1'b0};
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_acc) begin
                r_state <= n_state;
            end
            r_wr_ptr <= r_wr_ptr + w_npush;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_res.vld0) begin
            r_fifo[r_wr_ptr] <= {w_res.byte0, w_res.last0};
        end
        if (w_acc && w_res.vld1) begin
            r_fifo[r_wr_ptr + 2'd1] <= {w_res.byte1, 1'b1};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[1:0] == 2'(r_wr_ptr - r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_reset_plain: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state.mode == MODE_PLAIN && !r_state.high && r_count == 3'd0))
        else $error("decoder not in plain mode after reset");

    a_num_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_NUM) |->
            (r_state.is_hex ? (r_state.count < HEX_DIGITS) : (r_state.count < OCT_DIGITS)))
        else $error("digit count reached limit without emitting");

    a_num_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != MODE_NUM) |->
            (r_state.value == 9'd0 && r_state.count == 2'd0 && !r_state.is_hex))
        else $error("number state not cleared outside number mode");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tlast) |=> (r_state.mode == MODE_PLAIN && !r_state.high))
        else $error("end of text did not return decoder to plain mode");

endmodule

@@ sim/escaped_text_to_binary_decoder_unit_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the escaped text to binary decoder: watches both streams,
// predicts the restored bytes of each accepted character and compares them.
// Depends on etbd_pkg for the mode codes and character constants.
module escaped_text_to_binary_decoder_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_char
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  logic       i_m_tlast,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars_seen,
    output int         o_bytes_seen
);
    import etbd_pkg::*;

    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CTRL_MASK = 8'h1f;
    localparam logic [7:0] HIGH_BIT  = 8'h80;

    typedef struct packed {
        logic [7:0] restored;
        logic       tail;
    } t_expected_byte;

    t_expected_byte expected_bytes[$];
    logic [7:0]     step_bytes[$];

    t_mode      dmode  = MODE_PLAIN;
    logic       hflag  = 1'b0;
    logic [8:0] nval   = 9'd0;
    logic [1:0] ndig   = 2'd0;
    logic       nhex   = 1'b0;

    int fail_count = 0;
    int pending    = 0;
    int chars_seen = 0;
    int bytes_seen = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_chars_seen = chars_seen;
    assign o_bytes_seen = bytes_seen;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH at %0t ns: %s, got %02h, expected %02h", $time, what, got,
                 want);
        fail_count++;
    endtask

    task automatic put_flagged(input logic [7:0] v);
        step_bytes.push_back(v | (hflag ? HIGH_BIT : 8'h00));
        hflag = 1'b0;
    endtask

    task automatic clear_number();
        nval = 9'd0;
        ndig = 2'd0;
        nhex = 1'b0;
    endtask

    function automatic logic [4:0] digit_code(input logic [7:0] c, input logic hex);
        if (c >= CH_ZERO && c <= CH_SEVEN) digit_code = {1'b1, c[3:0]};
        else if (!hex) digit_code = 5'd0;
        else if (c > CH_SEVEN && c <= CH_NINE) digit_code = {1'b1, c[3:0]};
        else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F))
            digit_code = {1'b1, c[3:0] + 4'd9};
        else digit_code = 5'd0;
    endfunction

    task automatic plain_char(input logic [7:0] c);
        dmode = MODE_PLAIN;
        if (c == CH_TILDE) begin
            hflag = 1'b1;
            dmode = MODE_TILDE;
        end else if (c == CH_CARET) begin
            dmode = MODE_CARET;
        end else if (c == CH_BSL) begin
            dmode = MODE_BSL;
        end else begin
            put_flagged(c);
        end
    endtask

    task automatic start_number(input logic [7:0] letter, input logic hex);
        dmode = MODE_NUM;
        nhex  = hex;
        nval  = {1'b0, letter};
        ndig  = 2'd0;
    endtask

    task automatic decode_escape(input logic [7:0] c);
        dmode = MODE_PLAIN;
        case (c)
            CH_LF: ;
            CH_LO_D: put_flagged(BYTE_DEL);
            CH_LO_N: put_flagged(BYTE_LF);
            CH_LO_R: put_flagged(BYTE_CR);
            CH_LO_F: put_flagged(BYTE_FF);
            CH_LO_T: put_flagged(BYTE_TAB);
            CH_LO_B: put_flagged(BYTE_BS);
            CH_LO_E, CH_UP_E: put_flagged(BYTE_ESC);
            CH_LO_X, CH_UP_X: start_number(c, 1'b1);
            CH_ZERO: start_number(c, 1'b0);
            default: put_flagged(c);
        endcase
    endtask

    task automatic decode_digit(input logic [7:0] c);
        logic [4:0] dg;
        dg = digit_code(c, nhex);
        if (!dg[4]) begin
            if (!(ndig == 2'd0 && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))) begin
                put_flagged(nval[7:0]);
                clear_number();
                plain_char(c);
            end
        end else begin
            if (ndig == 2'd0) nval = {5'd0, dg[3:0]};
            else if (nhex) nval = {nval[4:0], 4'd0} + dg[3:0];
            else nval = {nval[5:0], 3'd0} + dg[3:0];
            ndig = ndig + 2'd1;
            if (ndig >= (nhex ? HEX_DIGITS : OCT_DIGITS)) begin
                put_flagged(nval[7:0]);
                clear_number();
                dmode = MODE_PLAIN;
            end
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic eot);
        logic [7:0]     c7;
        t_expected_byte e;
        c7 = {1'b0, c[6:0]};
        step_bytes.delete();
        case (dmode)
            MODE_TILDE: begin
                if (c7 == CH_CARET) begin
                    dmode = MODE_CARET;
                end else if (c7 == CH_BSL) begin
                    dmode = MODE_BSL;
                end else begin
                    put_flagged(c7);
                    dmode = MODE_PLAIN;
                end
            end
            MODE_CARET: begin
                put_flagged((c == CH_QMARK) ? BYTE_DEL : (c & CTRL_MASK));
                dmode = MODE_PLAIN;
            end
            MODE_BSL: decode_escape(c);
            MODE_NUM: decode_digit(c);
            default: plain_char(c);
        endcase
        if (eot) begin
            if (dmode == MODE_NUM) put_flagged(nval[7:0]);
            dmode = MODE_PLAIN;
            hflag = 1'b0;
            clear_number();
        end
        for (int i = 0; i < step_bytes.size(); i++) begin
            e.restored = step_bytes[i];
            e.tail     = (i == step_bytes.size() - 1);
            expected_bytes.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_expected_byte e;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                decode_char(i_s_tdata, i_s_tlast);
                chars_seen++;
            end
            if (i_m_tvalid && i_m_tready) begin
                bytes_seen++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch("byte with nothing expected", i_m_tdata, 8'h00);
                end else begin
                    e = expected_bytes.pop_front();
                    if (i_m_tdata != e.restored)
                        report_mismatch("out_byte", i_m_tdata, e.restored);
                    if (i_m_tlast != e.tail)
                        report_mismatch("run_last", {7'd0, i_m_tlast}, {7'd0, e.tail});
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

@@ sim/escaped_text_to_binary_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the escaped text to binary decoder testbench: clock, reset, text
// stimulus and verdict. Depends on etbd_pkg, the decoder and its checker.
module escaped_text_to_binary_decoder_unit_tb;
    import etbd_pkg::*;

    localparam int         PHASE_ITEMS   = 325;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         HOLD_AFTER    = 60;
    localparam int         WATCHDOG_MAX  = 2000;
    localparam int         TAIL_CYCLES   = 8;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_LO_A       = 8'h61;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_last;

    int fail_count;
    int pending;
    int chars_seen;
    int bytes_seen;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_idle_by_phase[4] = '{0, 55, 0, 14};
    int recv_stall_by_phase[4] = '{0, 0, 55, 14};

    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    logic [8:0] text_q[$];

    always #6 clk = ~clk;

    escaped_text_to_binary_decoder_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    escaped_text_to_binary_decoder_unit_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tlast    (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_chars_seen (chars_seen),
        .o_bytes_seen (bytes_seen)
    );

    // hold off the output once HOLD_AFTER characters have been accepted, so the queue fills up
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && rst_n && chars_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("escaped_text_to_binary_decoder_unit test failed");
            $finish;
        end
    end

    task automatic add_fixed(input logic [7:0] c, input logic eot);
        text_q.push_back({eot, c});
    endtask

    task automatic add_char(input logic [7:0] c);
        add_fixed(c, $urandom_range(39) == 0);
    endtask

    function automatic logic [7:0] space_char();
        int k;
        k = $urandom_range(5);
        space_char = (k == 5) ? CH_SPACE : CH_TAB + k[7:0];
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(15));
        if (v < 8'd10) hex_char = CH_ZERO + v;
        else hex_char = ($urandom_range(1) ? CH_LO_A : CH_UP_A) + v - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(11))
            0: escape_letter = CH_LO_D;
            1: escape_letter = CH_LO_N;
            2: escape_letter = CH_LO_R;
            3: escape_letter = CH_LO_F;
            4: escape_letter = CH_LO_T;
            5: escape_letter = CH_LO_B;
            6: escape_letter = CH_LO_E;
            7: escape_letter = CH_UP_E;
            8: escape_letter = CH_LF;
            default: escape_letter = 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind >= 48 && kind < 92 && $urandom_range(4) == 0) add_char(CH_TILDE);
        if (kind < 15) begin
            add_char(8'($urandom_range(255)));
        end else if (kind < 25) begin
            add_char(CH_TILDE);
            add_char(8'($urandom_range(255)));
        end else if (kind < 33) begin
            add_char(CH_CARET);
            add_char(8'($urandom_range(255)));
        end else if (kind < 48) begin
            add_char(CH_BSL);
            add_char(escape_letter());
        end else if (kind < 66) begin
            add_char(CH_BSL);
            add_char($urandom_range(1) ? CH_LO_X : CH_UP_X);
            repeat ($urandom_range(2)) add_char(space_char());
            n = $urandom_range(2);
            repeat (n) add_char(hex_char());
            if (n < 2 || $urandom_range(3) == 0) add_char(8'($urandom_range(255)));
        end else if (kind < 84) begin
            add_char(CH_BSL);
            add_char(CH_ZERO);
            repeat ($urandom_range(2)) add_char(space_char());
            n = $urandom_range(3);
            repeat (n) add_char(CH_ZERO + 8'($urandom_range(7)));
            if (n < 3 || $urandom_range(3) == 0) add_char(8'($urandom_range(255)));
        end else if (kind < 92) begin
            add_char(CH_TILDE);
            add_char(CH_BSL);
            add_char(CH_LF);
            add_char(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(255)));
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= eot;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text();
        logic [8:0] item;
        while (text_q.size() > 0) begin
            item = text_q.pop_front();
            send_char(item[7:0], item[8]);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        int sent_phase;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_fixed(CH_NUL, 1'b0);
        add_fixed(8'hff, 1'b0);
        add_fixed(CH_TILDE, 1'b0);
        add_fixed(CH_UP_A, 1'b0);
        add_fixed(CH_TILDE, 1'b0);
        add_fixed(8'hfe, 1'b0);
        add_fixed(CH_CARET, 1'b0);
        add_fixed(CH_QMARK, 1'b0);
        add_fixed(CH_BSL, 1'b0);
        add_fixed(CH_LO_E, 1'b0);
        // hex number with leading blank, ended by a non-digit
        add_fixed(CH_BSL, 1'b0);
        add_fixed(CH_LO_X, 1'b0);
        add_fixed(CH_SPACE, 1'b0);
        add_fixed(CH_LO_F, 1'b0);
        add_fixed(CH_LO_F + 8'd1, 1'b0);
        // line continuation keeps the high bit
        add_fixed(CH_TILDE, 1'b0);
        add_fixed(CH_BSL, 1'b0);
        add_fixed(CH_LF, 1'b0);
        add_fixed(8'h5a, 1'b0);
        // octal overflow past eight bits
        add_fixed(CH_BSL, 1'b0);
        add_fixed(CH_ZERO, 1'b0);
        add_fixed(CH_ZERO + 8'd7, 1'b0);
        add_fixed(CH_ZERO + 8'd7, 1'b0);
        add_fixed(CH_ZERO + 8'd7, 1'b0);
        // pending number flushed at end of text, then a dropped tilde
        add_fixed(CH_BSL, 1'b0);
        add_fixed(CH_UP_X, 1'b0);
        add_fixed(CH_LO_A, 1'b1);
        add_fixed(CH_TILDE, 1'b1);
        send_text();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_idle_by_phase[ph];
            recv_stall_pct = recv_stall_by_phase[ph];
            sent_phase = 0;
            while (sent_phase < PHASE_ITEMS) begin
                queue_random_sequence();
                sent_phase += text_q.size();
                send_text();
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Decoded %0d characters into %0d bytes: directed escapes, then random text",
                 chars_seen, bytes_seen);
        $display("under free flow, sender gaps, receiver stalls, both, and a long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("escaped_text_to_binary_decoder_unit test passed");
        end else begin
            $display("escaped_text_to_binary_decoder_unit test failed");
        end
        $finish;
    end

endmodule
